>>> sv/hsvd_pkg.sv
`timescale 1ns / 1ps

package hsvd_pkg;

	// fixed point: ONE = 1 << FRAC_BITS is 1.0
	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned ONE       = 1 << FRAC_BITS;
	localparam int unsigned CHAN_W    = FRAC_BITS + 1;
	localparam int unsigned HUE_OFS_W = 14;
	localparam int unsigned GAIN_W    = 16;

	// hue numerator and 6*delta both stay below 6 * 2^CHAN_W
	localparam int unsigned NUM_W     = CHAN_W + 3;
	localparam int unsigned DIV_STEPS = CHAN_W;

	// in, prep, divider steps, gain, sector, k terms, p/q/t, out
	localparam int unsigned PIPE_STAGES = DIV_STEPS + 7;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUE_OFFSET = 2'd0,
		CFG_SAT_GAIN   = 2'd1,
		CFG_VAL_GAIN   = 2'd2
	} cfg_idx_t;

endpackage

>>> sv/hsvd_ifs.sv
`timescale 1ns / 1ps

interface hsvd_pix_in_if;
	logic               valid;
	logic               ready;
	hsvd_pkg::chan_t    red_in;
	hsvd_pkg::chan_t    green_in;
	hsvd_pkg::chan_t    blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
	modport monitor (input valid, input red_in, input green_in, input blue_in,
		input ready);
endinterface

interface hsvd_pix_out_if;
	logic               valid;
	logic               ready;
	hsvd_pkg::chan_t    red_out;
	hsvd_pkg::chan_t    green_out;
	hsvd_pkg::chan_t    blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
	modport monitor (input valid, input red_out, input green_out, input blue_out,
		input ready);
endinterface

interface hsvd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [hsvd_pkg::CFG_IDX_W-1:0]      index;
	logic [hsvd_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
	modport monitor (input valid, input index, input data, input ready);
endinterface

>>> sv/hsv_color_distorter_unit.sv
`timescale 1ns / 1ps

// HSV color jitter for a pixel stream.
// pixel  : sink, one RGB beat (13 bit channels, 4096 = 1.0, larger codes used as is).
// result : source, one RGB beat per pixel beat, each channel clamped to 0..4096.
// cfg    : register writes, always ready; index 0 hue offset (14 bit signed, 4096 =
//          one turn), 1 saturation gain, 2 value gain (16 bit, 4096 = 1.0).
//          Write only while no pixel is in flight; other indexes are dropped.
// Throughput: one pixel per clock while the result side is ready.
// The depth is set by the two dividers (saturation and hue), which resolve one
// quotient bit per stage over 13 stages; the rest is the input register, max/delta prep,
// gains, hue wrap, sector terms, p/q/t multiplies and the clamp/select output register.
// Each stage has its own valid bit; a stage loads when it is empty or when the
// stage after it moves, so bubbles close up and a stalled result holds in the
// output register while earlier stages keep filling.
// Reset clears all valid bits and loads the register defaults (offset 0, gains 1.0).
module hsv_color_distorter_unit (
	input  logic            clk,
	input  logic            arst_n,
	hsvd_pix_in_if.sink     pixel,
	hsvd_pix_out_if.source  result,
	hsvd_cfg_if.sink        cfg
);

	localparam int FB    = hsvd_pkg::FRAC_BITS;
	localparam int CW    = hsvd_pkg::CHAN_W;
	localparam int GW    = hsvd_pkg::GAIN_W;
	localparam int NUMW  = hsvd_pkg::NUM_W;
	localparam int DSTEP = hsvd_pkg::DIV_STEPS;
	localparam int V_W   = CW + GW - FB;     // gained s and v
	localparam int K_W   = V_W + 1;          // signed (1 - x) terms
	localparam int P_W   = V_W + 1 + K_W;    // v2 * k product
	localparam int R_W   = P_W - FB;         // p, q, t before clamp

	// stage numbers
	localparam int S_DIV0 = 3;
	localparam int S_GAIN = S_DIV0 + DSTEP;
	localparam int NS     = S_GAIN + 4;

	// ---------------- configuration registers ----------------
	logic signed [hsvd_pkg::HUE_OFS_W-1:0] hue_ofs_q;
	logic [GW-1:0]                         sat_gain_q;
	logic [GW-1:0]                         val_gain_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_ofs_q  <= '0;
			sat_gain_q <= GW'(hsvd_pkg::ONE);
			val_gain_q <= GW'(hsvd_pkg::ONE);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				hsvd_pkg::CFG_HUE_OFFSET: hue_ofs_q  <= cfg.data[hsvd_pkg::HUE_OFS_W-1:0];
				hsvd_pkg::CFG_SAT_GAIN:   sat_gain_q <= cfg.data[GW-1:0];
				hsvd_pkg::CFG_VAL_GAIN:   val_gain_q <= cfg.data[GW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline flow control ----------------
	logic [NS:1]   pipe_vld_q;
	logic [NS+1:1] rdy;

	assign rdy[NS+1] = result.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_flow
		logic vld_prev;
		assign rdy[k] = !pipe_vld_q[k] || rdy[k+1];
		if (k == 1) begin : g_head
			assign vld_prev = pixel.valid;
		end else begin : g_body
			assign vld_prev = pipe_vld_q[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				pipe_vld_q[k] <= vld_prev;
			end
		end
	end

	assign pixel.ready  = rdy[1];
	assign result.valid = pipe_vld_q[NS];

	// ---------------- stage 1: input register ----------------
	logic [CW-1:0] r_s1, g_s1, b_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			r_s1 <= pixel.red_in;
			g_s1 <= pixel.green_in;
			b_s1 <= pixel.blue_in;
		end
	end

	// ---------------- stage 2: max, delta, hue numerator ----------------
	logic [CW-1:0]            mx_c, mn_c, dl_c;
	logic signed [NUMW+1:0]   sr, sg, sb, sd, num_c;
	logic [NUMW-1:0]          d6_c;

	always_comb begin
		mx_c = (r_s1 > g_s1) ? ((r_s1 > b_s1) ? r_s1 : b_s1) : ((g_s1 > b_s1) ? g_s1 : b_s1);
		mn_c = (r_s1 < g_s1) ? ((r_s1 < b_s1) ? r_s1 : b_s1) : ((g_s1 < b_s1) ? g_s1 : b_s1);
		dl_c = mx_c - mn_c;
		sr   = $signed((NUMW+2)'(r_s1));
		sg   = $signed((NUMW+2)'(g_s1));
		sb   = $signed((NUMW+2)'(b_s1));
		sd   = $signed((NUMW+2)'(dl_c));
		d6_c = NUMW'(dl_c) * NUMW'(6);
		// tie on max: red first, then green
		if (r_s1 == mx_c) begin
			num_c = sg - sb;
			if (num_c < 0) begin
				num_c = num_c + (NUMW+2)'(sd * 6);
			end
		end else if (g_s1 == mx_c) begin
			num_c = (NUMW+2)'(sd * 2) + sb - sr;
		end else begin
			num_c = (NUMW+2)'(sd * 4) + sr - sg;
		end
	end

	logic [CW-1:0]   mx_s2, dl_s2;
	logic [NUMW-1:0] num_s2, d6_s2;
	logic            szero_s2, hzero_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			mx_s2    <= mx_c;
			dl_s2    <= dl_c;
			num_s2   <= num_c[NUMW-1:0];
			d6_s2    <= d6_c;
			szero_s2 <= (mx_c == '0);   // black: s and h are zero
			hzero_s2 <= (dl_c == '0);   // gray: h is zero
		end
	end

	// ---------------- stages 3..15: dividers ----------------
	// s = delta * ONE / max, h = num * ONE / (6 * delta)
	logic [DSTEP-1:0] quo_s, quo_h;
	logic [CW:0]      sbo_s;
	logic             sbo_h;

	hsvd_div #(
		.NW(CW + FB), .DW(CW), .QW(DSTEP), .SBW(CW + 1)
	) u_div_sat (
		.clk(clk),
		.en(rdy[S_DIV0 +: DSTEP]),
		.num({dl_s2, FB'(0)}),
		.den(mx_s2),
		.sb_in({szero_s2, mx_s2}),
		.quo(quo_s),
		.sb_out(sbo_s)
	);

	hsvd_div #(
		.NW(NUMW + FB), .DW(NUMW), .QW(DSTEP), .SBW(1)
	) u_div_hue (
		.clk(clk),
		.en(rdy[S_DIV0 +: DSTEP]),
		.num({num_s2, FB'(0)}),
		.den(d6_s2),
		.sb_in(hzero_s2),
		.quo(quo_h),
		.sb_out(sbo_h)
	);

	// ---------------- stage 16: gains and hue wrap ----------------
	logic [CW-1:0]    s_c;
	logic [FB-1:0]    h_c, hue_c;
	logic [CW+GW-1:0] sprod_c, vprod_c;

	always_comb begin
		s_c     = sbo_s[CW] ? '0 : quo_s[CW-1:0];
		h_c     = sbo_h ? '0 : quo_h[FB-1:0];
		sprod_c = (CW+GW)'(s_c) * (CW+GW)'(sat_gain_q);
		vprod_c = (CW+GW)'(sbo_s[CW-1:0]) * (CW+GW)'(val_gain_q);
		hue_c   = h_c + hue_ofs_q[FB-1:0];   // mod one turn
	end

	logic [V_W-1:0] s2_s16, v2_s16;
	logic [FB-1:0]  hue_s16;

	always_ff @(posedge clk) begin
		if (rdy[S_GAIN]) begin
			s2_s16  <= sprod_c[CW+GW-1:FB];
			v2_s16  <= vprod_c[CW+GW-1:FB];
			hue_s16 <= hue_c;
		end
	end

	// ---------------- stage 17: sector and fraction ----------------
	logic [FB+2:0] h6_c;
	assign h6_c = (FB+3)'(hue_s16) * (FB+3)'(6);

	logic [2:0]     sector_s17;
	logic [FB-1:0]  frac_s17;
	logic [V_W-1:0] s2_s17, v2_s17;

	always_ff @(posedge clk) begin
		if (rdy[S_GAIN+1]) begin
			sector_s17 <= h6_c[FB+2:FB];
			frac_s17   <= h6_c[FB-1:0];
			s2_s17     <= s2_s16;
			v2_s17     <= v2_s16;
		end
	end

	// ---------------- stage 18: one-minus terms ----------------
	logic [V_W+FB-1:0] aprod_c;
	logic [V_W+FB:0]   bprod_c;
	logic [FB:0]       omf_c;

	always_comb begin
		omf_c   = (FB+1)'(hsvd_pkg::ONE) - (FB+1)'(frac_s17);
		aprod_c = (V_W+FB)'(s2_s17) * (V_W+FB)'(frac_s17);
		bprod_c = (V_W+FB+1)'(s2_s17) * (V_W+FB+1)'(omf_c);
	end

	logic signed [K_W-1:0] kp_s18, kq_s18, kt_s18;
	logic [2:0]            sector_s18;
	logic [V_W-1:0]        v2_s18;

	always_ff @(posedge clk) begin
		if (rdy[S_GAIN+2]) begin
			kp_s18     <= $signed(K_W'(hsvd_pkg::ONE) - K_W'(s2_s17));
			kq_s18     <= $signed(K_W'(hsvd_pkg::ONE) - K_W'(aprod_c[V_W+FB-1:FB]));
			kt_s18     <= $signed(K_W'(hsvd_pkg::ONE) - K_W'(bprod_c[V_W+FB:FB]));
			sector_s18 <= sector_s17;
			v2_s18     <= v2_s17;
		end
	end

	// ---------------- stage 19: p, q, t ----------------
	logic signed [P_W-1:0] pp_c, pq_c, pt_c;
	logic signed [K_W-1:0] v2x_c;

	always_comb begin
		v2x_c = $signed({1'b0, v2_s18});
		pp_c  = v2x_c * kp_s18;
		pq_c  = v2x_c * kq_s18;
		pt_c  = v2x_c * kt_s18;
	end

	logic signed [R_W-1:0] p_s19, q_s19, t_s19;
	logic [2:0]            sector_s19;
	logic [V_W-1:0]        v2_s19;

	always_ff @(posedge clk) begin
		if (rdy[S_GAIN+3]) begin
			p_s19      <= pp_c[P_W-1:FB];   // arithmetic shift = floor
			q_s19      <= pq_c[P_W-1:FB];
			t_s19      <= pt_c[P_W-1:FB];
			sector_s19 <= sector_s18;
			v2_s19     <= v2_s18;
		end
	end

	// ---------------- stage 20: select, clamp, output register ----------------
	function automatic logic [CW-1:0] clamp_unit(input logic signed [R_W-1:0] x);
		logic [CW-1:0] y;
		if (x < 0) begin
			y = '0;
		end else if (x > $signed(R_W'(hsvd_pkg::ONE))) begin
			y = CW'(hsvd_pkg::ONE);
		end else begin
			y = x[CW-1:0];
		end
		return y;
	endfunction

	logic signed [R_W-1:0] v_c, ro_c, go_c, bo_c;

	always_comb begin
		v_c = $signed(R_W'(v2_s19));
		case (sector_s19)
			3'd0:    begin ro_c = v_c;   go_c = t_s19; bo_c = p_s19; end
			3'd1:    begin ro_c = q_s19; go_c = v_c;   bo_c = p_s19; end
			3'd2:    begin ro_c = p_s19; go_c = v_c;   bo_c = t_s19; end
			3'd3:    begin ro_c = p_s19; go_c = q_s19; bo_c = v_c;   end
			3'd4:    begin ro_c = t_s19; go_c = p_s19; bo_c = v_c;   end
			default: begin ro_c = v_c;   go_c = p_s19; bo_c = q_s19; end
		endcase
	end

	logic [CW-1:0] red_s20, green_s20, blue_s20;

	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			red_s20   <= clamp_unit(ro_c);
			green_s20 <= clamp_unit(go_c);
			blue_s20  <= clamp_unit(bo_c);
		end
	end

	assign result.red_out   = red_s20;
	assign result.green_out = green_s20;
	assign result.blue_out  = blue_s20;

endmodule

>>> sv/hsvd_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Requires num[NW-1:QW] < den (quotient fits in QW bits).
module hsvd_div #(
	parameter int NW  = 25,
	parameter int DW  = 13,
	parameter int QW  = 13,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic [QW-1:0]  en,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [SBW-1:0] sb_in,
	output logic [QW-1:0]  quo,
	output logic [SBW-1:0] sb_out
);

	logic [DW-1:0]  rem_s [QW];
	logic [QW-1:0]  low_s [QW];
	logic [QW-1:0]  quo_s [QW];
	logic [DW-1:0]  den_s [QW];
	logic [SBW-1:0] sb_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0]  rem_p;
		logic [DW-1:0]  den_p;
		logic [QW-1:0]  low_p;
		logic [QW-1:0]  quo_p;
		logic [SBW-1:0] sb_p;
		logic [DW:0]    trial;
		logic [DW:0]    diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_p = DW'(num[NW-1:QW]);
			assign low_p = num[QW-1:0];
			assign quo_p = '0;
			assign den_p = den;
			assign sb_p  = sb_in;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign low_p = low_s[k-1];
			assign quo_p = quo_s[k-1];
			assign den_p = den_s[k-1];
			assign sb_p  = sb_s[k-1];
		end

		assign trial = {rem_p, low_p[QW-1]};
		assign diff  = trial - {1'b0, den_p};
		assign ge    = (trial >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				low_s[k] <= {low_p[QW-2:0], 1'b0};
				quo_s[k] <= {quo_p[QW-2:0], ge};
				den_s[k] <= den_p;
				sb_s[k]  <= sb_p;
			end
		end
	end

	assign quo    = quo_s[QW-1];
	assign sb_out = sb_s[QW-1];

endmodule

>>> sv/hsvd_chk.sv
`timescale 1ns / 1ps

module hsvd_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [hsvd_pkg::CHAN_W-1:0] red,
	input logic [hsvd_pkg::CHAN_W-1:0] green,
	input logic [hsvd_pkg::CHAN_W-1:0] blue
);

	logic [5:0] cnt_q;   // pixels in flight

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 6'(in_valid && in_ready) - 6'(out_valid && out_ready);
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != '0))
		else $error("result beat with no pixel in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(hsvd_pkg::PIPE_STAGES))
		else $error("more pixels in flight than pipeline stages");

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= hsvd_pkg::CHAN_W'(hsvd_pkg::ONE)) &&
			(green <= hsvd_pkg::CHAN_W'(hsvd_pkg::ONE)) &&
			(blue <= hsvd_pkg::CHAN_W'(hsvd_pkg::ONE)))
		else $error("channel above 1.0");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) &&
			$stable(blue))
		else $error("stalled result beat changed");

endmodule

bind hsv_color_distorter_unit hsvd_chk u_hsvd_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pixel.valid),
	.in_ready(pixel.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.red(result.red_out),
	.green(result.green_out),
	.blue(result.blue_out)
);
